FILE: hdl/bsd_pkg.sv
package bsd_pkg;

  // Field widths.
  localparam int VALUE_BITS = 24;
  localparam int DEV_W      = VALUE_BITS - 1;
  localparam int REP_W      = 13;
  localparam int CNT_W      = 16;
  localparam int OCNT_W     = 32;
  localparam int PCNT_W     = CNT_W + REP_W;

  // A block never holds more than 2**REP_W - 1 records, which bounds the sums.
  localparam int SUM_W  = VALUE_BITS + REP_W;
  localparam int SQE_W  = 2 * VALUE_BITS - 1;
  localparam int SQ_W   = SQE_W + REP_W;
  localparam int ROOT_W = SQ_W / 2;
  localparam int DCNT_W = $clog2(SQ_W);
  localparam int SCNT_W = $clog2(ROOT_W);

  localparam logic [REP_W-1:0] BLOCK_SIZE_RESET = REP_W'(10);
  localparam logic [VALUE_BITS-1:0] VMAX = {1'b0, {(VALUE_BITS - 1){1'b1}}};
  localparam logic [VALUE_BITS-1:0] VMIN = {1'b1, {(VALUE_BITS - 1){1'b0}}};

  localparam logic KIND_SUMMARY = 1'b0;
  localparam logic KIND_PASS    = 1'b1;

  typedef enum logic [1:0] {
    DIV_MEAN,
    DIV_MSQ,
    DIV_PASS
  } div_op_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CHECK,
    S_SQ_SUM,
    S_ACC_MUL,
    S_ACC_ADD,
    S_MEAN_LOAD,
    S_MEAN_RUN,
    S_MEAN_FIN,
    S_MSQ_LOAD,
    S_MSQ_RUN,
    S_MSQ_FIN,
    S_SQRT_LOAD,
    S_SQRT_RUN,
    S_SQRT_FIN,
    S_OUT_SUM,
    S_PASS_LOAD,
    S_PASS_RUN,
    S_PASS_FIN,
    S_OUT_PASS
  } state_t;

  typedef struct packed {
    logic    latch;
    logic    check;
    logic    sq_sum;
    logic    acc_mul;
    logic    acc_add;
    logic    fill_add;
    logic    merge;
    logic    tail_load;
    logic    div_start;
    div_op_t div_op;
    logic    div_step;
    logic    mean_set;
    logic    m2_set;
    logic    var_set;
    logic    sqrt_start;
    logic    sqrt_step;
    logic    load_summary;
    logic    load_pass;
    logic    clear_pool;
  } cmd_t;

  typedef struct packed {
    logic close;
    logic pass;
    logic krem_nz;
    logic div_last;
    logic sqrt_last;
  } status_t;

endpackage

FILE: hdl/bsd_if.sv
interface bsd_cfg_if;
  import bsd_pkg::*;
  logic             valid;
  logic             ready;
  logic [REP_W-1:0] block_size;
  modport source(output valid, output block_size, input ready);
  modport sink(input valid, input block_size, output ready);
endinterface

interface bsd_in_if;
  import bsd_pkg::*;
  logic                         valid;
  logic                         ready;
  logic [REP_W-1:0]             repeat_req;
  logic [CNT_W-1:0]             sample_count;
  logic signed [VALUE_BITS-1:0] min_value;
  logic signed [VALUE_BITS-1:0] avg_value;
  logic signed [VALUE_BITS-1:0] max_value;
  logic [DEV_W-1:0]             dev_value;
  modport source(output valid, output repeat_req, output sample_count, output min_value,
                 output avg_value, output max_value, output dev_value, input ready);
  modport sink(input valid, input repeat_req, input sample_count, input min_value,
               input avg_value, input max_value, input dev_value, output ready);
endinterface

interface bsd_out_if;
  import bsd_pkg::*;
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic [REP_W-1:0]             repeat_out;
  logic [OCNT_W-1:0]            count_out;
  logic signed [VALUE_BITS-1:0] min_out;
  logic signed [VALUE_BITS-1:0] avg_out;
  logic signed [VALUE_BITS-1:0] max_out;
  logic [DEV_W-1:0]             dev_out;
  logic                         last;
  modport source(output valid, output kind, output repeat_out, output count_out,
                 output min_out, output avg_out, output max_out, output dev_out,
                 output last, input ready);
  modport sink(input valid, input kind, input repeat_out, input count_out, input min_out,
               input avg_out, input max_out, input dev_out, input last, output ready);
endinterface

FILE: hdl/bsd_dp.sv
module bsd_dp (
  input  logic                                  clk,
  input  logic                                  rst,
  input  bsd_pkg::cmd_t                         cmd,
  output bsd_pkg::status_t                      st,
  input  logic                                  cfg_valid,
  input  logic [bsd_pkg::REP_W-1:0]             cfg_block_size,
  input  logic [bsd_pkg::REP_W-1:0]             repeat_req,
  input  logic [bsd_pkg::CNT_W-1:0]             sample_count,
  input  logic signed [bsd_pkg::VALUE_BITS-1:0] min_value,
  input  logic signed [bsd_pkg::VALUE_BITS-1:0] avg_value,
  input  logic signed [bsd_pkg::VALUE_BITS-1:0] max_value,
  input  logic [bsd_pkg::DEV_W-1:0]             dev_value,
  output logic                                  kind,
  output logic [bsd_pkg::REP_W-1:0]             repeat_out,
  output logic [bsd_pkg::OCNT_W-1:0]            count_out,
  output logic signed [bsd_pkg::VALUE_BITS-1:0] min_out,
  output logic signed [bsd_pkg::VALUE_BITS-1:0] avg_out,
  output logic signed [bsd_pkg::VALUE_BITS-1:0] max_out,
  output logic [bsd_pkg::DEV_W-1:0]             dev_out,
  output logic                                  last
);
  import bsd_pkg::*;

  // Configuration and pooled state.
  logic [REP_W-1:0]             block_size;
  logic [REP_W-1:0]             fill;
  logic [OCNT_W-1:0]            pool_count;
  logic signed [VALUE_BITS-1:0] pool_min;
  logic signed [VALUE_BITS-1:0] pool_max;
  logic [SUM_W-1:0]             pool_sum;
  logic [SQ_W-1:0]              pool_sq;

  // Latched item and per-item working values.
  logic [REP_W-1:0]             k_r;
  logic [CNT_W-1:0]             cnt_r;
  logic signed [VALUE_BITS-1:0] mn_r;
  logic signed [VALUE_BITS-1:0] av_r;
  logic signed [VALUE_BITS-1:0] mx_r;
  logic [DEV_W-1:0]             dv_r;
  logic                         close_r;
  logic                         pass_r;
  logic [REP_W-1:0]             acc_k;
  logic [REP_W-1:0]             krem;
  logic [SQE_W-1:0]             sq_a;
  logic [SQE_W-1:0]             sq_d;
  logic [SQE_W-1:0]             sq;
  logic [PCNT_W-1:0]            prod_cnt;
  logic [SUM_W-1:0]             prod_sum;
  logic [SQ_W-1:0]              prod_sq;

  // Divider, mean and square root registers.
  logic [SQ_W-1:0]              dvd;
  logic [REP_W-1:0]             drem;
  logic [DCNT_W-1:0]            dcnt;
  logic                         div_busy;
  logic signed [VALUE_BITS-1:0] mean;
  logic [SQE_W-1:0]             m2;
  logic [SQ_W-1:0]              var_r;
  logic [SQ_W-1:0]              sx;
  logic [ROOT_W-1:0]            root;
  logic [ROOT_W:0]              srem;
  logic [SCNT_W-1:0]            scnt;
  logic                         sqrt_busy;

  // Combinational helpers.
  logic [REP_W-1:0]             r_eff;
  logic [REP_W:0]               fk_sum;
  logic                         close_c;
  logic [REP_W-1:0]             take;
  logic [REP_W-1:0]             kr;
  logic [VALUE_BITS-1:0]        a_abs;
  logic [2*VALUE_BITS-1:0]      a_sq_full;
  logic [2*DEV_W-1:0]           d_sq_full;
  logic signed [SUM_W:0]        psum_full;
  logic [OCNT_W:0]              cnt_sum;
  logic [SUM_W-1:0]             sum_abs;
  logic [SUM_W-1:0]             mean_dvd;
  logic [REP_W:0]               dtrial;
  logic                         dge;
  logic [REP_W:0]               ddiff;
  logic [SUM_W-1:0]             q_mean;
  logic [VALUE_BITS-1:0]        mean_c;
  logic [VALUE_BITS-1:0]        m_abs;
  logic [2*VALUE_BITS-1:0]      m2_full;
  logic                         msq_up;
  logic [SQ_W-1:0]              msq;
  logic [ROOT_W+2:0]            strial_rem;
  logic [ROOT_W+2:0]            strial;
  logic                         sge;
  logic [ROOT_W+2:0]            sdiff;
  logic                         root_up;
  logic [ROOT_W:0]              dev_w;
  logic [DEV_W-1:0]             dev_c;

  // Item decision: does the block close, and how many records go where.
  always_comb begin
    r_eff   = (block_size == '0) ? REP_W'(1) : block_size;
    fk_sum  = {1'b0, fill} + {1'b0, k_r};
    close_c = fk_sum >= {1'b0, r_eff};
    take    = (r_eff > fill) ? r_eff - fill : '0;
    kr      = k_r - take;
  end

  // Squares of the record and the weighted terms.
  always_comb begin
    a_abs     = av_r[VALUE_BITS-1] ? VALUE_BITS'(~av_r + 1'b1) : av_r;
    a_sq_full = a_abs * a_abs;
    d_sq_full = dv_r * dv_r;
    psum_full = $signed({1'b0, acc_k}) * av_r;
    cnt_sum   = {1'b0, pool_count} + (OCNT_W + 1)'(prod_cnt);
  end

  // Divider step: one quotient bit per cycle against the block size.
  always_comb begin
    sum_abs  = pool_sum[SUM_W-1] ? SUM_W'(~pool_sum + 1'b1) : pool_sum;
    mean_dvd = sum_abs + SUM_W'(r_eff >> 1);
    dtrial   = {drem, dvd[SQ_W-1]};
    dge      = dtrial >= {1'b0, r_eff};
    ddiff    = dtrial - {1'b0, r_eff};
  end

  // Mean rounding and saturation, then the mean square.
  always_comb begin
    q_mean = dvd[SUM_W-1:0];
    if (pool_sum[SUM_W-1]) begin
      mean_c = (q_mean > SUM_W'(VMIN)) ? VMIN : VALUE_BITS'(~q_mean[VALUE_BITS-1:0] + 1'b1);
    end else begin
      mean_c = (q_mean > SUM_W'(VMAX)) ? VMAX : q_mean[VALUE_BITS-1:0];
    end
    m_abs   = mean[VALUE_BITS-1] ? VALUE_BITS'(~mean + 1'b1) : mean;
    m2_full = m_abs * m_abs;
    msq_up  = {1'b0, drem} >= ({1'b0, r_eff} - {1'b0, drem});
    msq     = dvd + SQ_W'(msq_up);
  end

  // Square root step: two radicand bits per cycle.
  always_comb begin
    strial_rem = {srem, sx[SQ_W-1 -: 2]};
    strial     = {1'b0, root, 2'b01};
    sge        = strial_rem >= strial;
    sdiff      = strial_rem - strial;
    root_up    = srem > {1'b0, root};
    dev_w      = {1'b0, root} + (ROOT_W + 1)'(root_up);
    dev_c      = (dev_w > (ROOT_W + 1)'({DEV_W{1'b1}})) ? {DEV_W{1'b1}} : dev_w[DEV_W-1:0];
  end

  // Status back to the controller.
  always_comb begin
    st.close     = close_r;
    st.pass      = pass_r;
    st.krem_nz   = krem != '0;
    st.div_last  = dcnt == '0;
    st.sqrt_last = scnt == '0;
  end

  // Architectural state with reset values.
  always_ff @(posedge clk) begin
    if (rst) begin
      block_size <= BLOCK_SIZE_RESET;
      fill       <= '0;
      pool_count <= '0;
      pool_min   <= VMAX;
      pool_max   <= VMIN;
      pool_sum   <= '0;
      pool_sq    <= '0;
      div_busy   <= 1'b0;
      sqrt_busy  <= 1'b0;
      drem       <= '0;
      srem       <= '0;
      root       <= '0;
    end else begin
      if (cfg_valid) begin
        block_size <= cfg_block_size;
      end
      if (cmd.check || cmd.merge) begin
        if (mn_r < pool_min) begin
          pool_min <= mn_r;
        end
        if (mx_r > pool_max) begin
          pool_max <= mx_r;
        end
      end
      if (cmd.acc_add) begin
        pool_count <= cnt_sum[OCNT_W] ? {OCNT_W{1'b1}} : cnt_sum[OCNT_W-1:0];
        pool_sum   <= pool_sum + prod_sum;
        pool_sq    <= pool_sq + prod_sq;
      end
      if (cmd.fill_add) begin
        fill <= fill + acc_k;
      end
      if (cmd.clear_pool) begin
        fill       <= '0;
        pool_count <= '0;
        pool_min   <= VMAX;
        pool_max   <= VMIN;
        pool_sum   <= '0;
        pool_sq    <= '0;
      end
      if (cmd.div_start) begin
        div_busy <= 1'b1;
        drem     <= '0;
      end else if (cmd.div_step) begin
        drem <= dge ? ddiff[REP_W-1:0] : dtrial[REP_W-1:0];
        if (dcnt == '0) begin
          div_busy <= 1'b0;
        end
      end
      if (cmd.sqrt_start) begin
        sqrt_busy <= 1'b1;
        srem      <= '0;
        root      <= '0;
      end else if (cmd.sqrt_step) begin
        srem <= sge ? sdiff[ROOT_W:0] : strial_rem[ROOT_W:0];
        root <= {root[ROOT_W-2:0], sge};
        if (scnt == '0) begin
          sqrt_busy <= 1'b0;
        end
      end
    end
  end

  // Working registers and the output record.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      k_r   <= repeat_req;
      cnt_r <= sample_count;
      mn_r  <= min_value;
      av_r  <= avg_value;
      mx_r  <= max_value;
      dv_r  <= dev_value;
    end
    if (cmd.check) begin
      close_r <= close_c;
      pass_r  <= close_c && (kr >= r_eff);
      acc_k   <= close_c ? take : k_r;
      krem    <= close_c ? kr : '0;
      sq_a    <= a_sq_full[SQE_W-1:0];
      sq_d    <= SQE_W'(d_sq_full);
    end
    if (cmd.sq_sum) begin
      sq <= sq_a + sq_d;
    end
    if (cmd.acc_mul) begin
      prod_cnt <= acc_k * cnt_r;
      prod_sum <= psum_full[SUM_W-1:0];
      prod_sq  <= sq * acc_k;
    end
    if (cmd.tail_load) begin
      acc_k <= krem;
    end
    if (cmd.div_start) begin
      case (cmd.div_op)
        DIV_MEAN: begin
          dvd  <= {mean_dvd, {(SQ_W - SUM_W){1'b0}}};
          dcnt <= DCNT_W'(SUM_W - 1);
        end
        DIV_MSQ: begin
          dvd  <= pool_sq;
          dcnt <= DCNT_W'(SQ_W - 1);
        end
        DIV_PASS: begin
          dvd  <= {krem, {(SQ_W - REP_W){1'b0}}};
          dcnt <= DCNT_W'(REP_W - 1);
        end
        default: begin
          dvd  <= '0;
          dcnt <= '0;
        end
      endcase
    end else if (cmd.div_step) begin
      dvd  <= {dvd[SQ_W-2:0], dge};
      dcnt <= dcnt - 1'b1;
    end
    if (cmd.mean_set) begin
      mean <= mean_c;
    end
    if (cmd.m2_set) begin
      m2 <= m2_full[SQE_W-1:0];
    end
    if (cmd.var_set) begin
      var_r <= (msq > SQ_W'(m2)) ? msq - SQ_W'(m2) : '0;
    end
    if (cmd.sqrt_start) begin
      sx   <= var_r;
      scnt <= SCNT_W'(ROOT_W - 1);
    end else if (cmd.sqrt_step) begin
      sx   <= {sx[SQ_W-3:0], 2'b00};
      scnt <= scnt - 1'b1;
    end
    if (cmd.load_summary) begin
      kind       <= KIND_SUMMARY;
      repeat_out <= REP_W'(1);
      count_out  <= pool_count;
      min_out    <= pool_min;
      avg_out    <= mean;
      max_out    <= pool_max;
      dev_out    <= dev_c;
      last       <= !pass_r;
    end
    if (cmd.load_pass) begin
      kind       <= KIND_PASS;
      repeat_out <= dvd[REP_W-1:0];
      count_out  <= OCNT_W'(cnt_r);
      min_out    <= mn_r;
      avg_out    <= av_r;
      max_out    <= mx_r;
      dev_out    <= dv_r;
      last       <= 1'b1;
      krem       <= drem;
    end
  end

  // The partial remainder of a division stays below the divisor.
  assert property (@(posedge clk) disable iff (rst) div_busy |-> (drem < r_eff))
    else $error("divider remainder not below block size");

  // The square root remainder never exceeds twice the partial root.
  assert property (@(posedge clk) disable iff (rst) sqrt_busy |-> (srem <= {root, 1'b0}))
    else $error("square root remainder out of bound");

  // A division is only stepped while one is in progress.
  assert property (@(posedge clk) disable iff (rst) cmd.div_step |-> div_busy)
    else $error("divider stepped while idle");

endmodule

FILE: hdl/bsd_ctrl.sv
module bsd_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output bsd_pkg::cmd_t    cmd,
  input  bsd_pkg::status_t st
);
  import bsd_pkg::*;

  state_t state;
  state_t state_next;
  logic   tail;
  logic   tail_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      tail  <= 1'b0;
    end else begin
      state <= state_next;
      tail  <= tail_next;
    end
  end

  // Next state and commands to the datapath.
  always_comb begin
    state_next = state;
    tail_next  = tail;
    cmd        = '0;
    cmd.div_op = DIV_MEAN;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready  = 1'b1;
        tail_next = 1'b0;
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check  = 1'b1;
        state_next = S_SQ_SUM;
      end
      S_SQ_SUM: begin
        cmd.sq_sum = 1'b1;
        state_next = S_ACC_MUL;
      end
      S_ACC_MUL: begin
        cmd.acc_mul = 1'b1;
        state_next  = S_ACC_ADD;
      end
      S_ACC_ADD: begin
        cmd.acc_add = 1'b1;
        if (tail) begin
          cmd.fill_add = 1'b1;
          cmd.merge    = 1'b1;
          state_next   = S_IDLE;
        end else if (!st.close) begin
          cmd.fill_add = 1'b1;
          state_next   = S_IDLE;
        end else begin
          state_next = S_MEAN_LOAD;
        end
      end
      S_MEAN_LOAD: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = DIV_MEAN;
        state_next    = S_MEAN_RUN;
      end
      S_MEAN_RUN: begin
        cmd.div_step = 1'b1;
        if (st.div_last) begin
          state_next = S_MEAN_FIN;
        end
      end
      S_MEAN_FIN: begin
        cmd.mean_set = 1'b1;
        state_next   = S_MSQ_LOAD;
      end
      S_MSQ_LOAD: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = DIV_MSQ;
        cmd.m2_set    = 1'b1;
        state_next    = S_MSQ_RUN;
      end
      S_MSQ_RUN: begin
        cmd.div_step = 1'b1;
        if (st.div_last) begin
          state_next = S_MSQ_FIN;
        end
      end
      S_MSQ_FIN: begin
        cmd.var_set = 1'b1;
        state_next  = S_SQRT_LOAD;
      end
      S_SQRT_LOAD: begin
        cmd.sqrt_start = 1'b1;
        state_next     = S_SQRT_RUN;
      end
      S_SQRT_RUN: begin
        cmd.sqrt_step = 1'b1;
        if (st.sqrt_last) begin
          state_next = S_SQRT_FIN;
        end
      end
      S_SQRT_FIN: begin
        cmd.load_summary = 1'b1;
        state_next       = S_OUT_SUM;
      end
      S_OUT_SUM: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.clear_pool = 1'b1;
          if (st.pass) begin
            state_next = S_PASS_LOAD;
          end else if (st.krem_nz) begin
            cmd.tail_load = 1'b1;
            tail_next     = 1'b1;
            state_next    = S_ACC_MUL;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_PASS_LOAD: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = DIV_PASS;
        state_next    = S_PASS_RUN;
      end
      S_PASS_RUN: begin
        cmd.div_step = 1'b1;
        if (st.div_last) begin
          state_next = S_PASS_FIN;
        end
      end
      S_PASS_FIN: begin
        cmd.load_pass = 1'b1;
        state_next    = S_OUT_PASS;
      end
      S_OUT_PASS: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (st.krem_nz) begin
            cmd.tail_load = 1'b1;
            tail_next     = 1'b1;
            state_next    = S_ACC_MUL;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // A stalled result keeps the controller in its output state.
  assert property (@(posedge clk) disable iff (rst)
                   (out_valid && !out_ready) |=> (out_valid && $stable(state)))
    else $error("result dropped while stalled");

  // The remainder pass never closes a block or shows a result.
  assert property (@(posedge clk) disable iff (rst) tail |-> !cmd.load_summary)
    else $error("summary produced during remainder pass");

  // The pool is cleared only when a summary transaction completes.
  assert property (@(posedge clk) disable iff (rst)
                   cmd.clear_pool |-> (state == S_OUT_SUM && out_ready))
    else $error("pool cleared outside summary transaction");

endmodule

FILE: hdl/block_statistics_decimator_core.sv
// An item that closes no block passes the check, square-sum, multiply and add states.
// Closing a block runs a 37-step mean division and a 60-step mean-square division
// on one shared bit-serial divider, then a 30-step bit-serial square root.
// A passthrough record adds a further division; one item is processed at a time.
// Reset (synchronous, rst high) sets block_size to 10 and empties the pool.
module block_statistics_decimator_core (
  input logic   clk,
  input logic   rst,
  bsd_cfg_if.sink cfg,
  bsd_in_if.sink  items,
  bsd_out_if.source results
);
  import bsd_pkg::*;

  cmd_t    cmd;
  status_t st;

  // Configuration writes are taken at any time.
  assign cfg.ready = 1'b1;

  bsd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (items.valid),
    .in_ready  (items.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .cmd       (cmd),
    .st        (st)
  );

  bsd_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .st             (st),
    .cfg_valid      (cfg.valid),
    .cfg_block_size (cfg.block_size),
    .repeat_req     (items.repeat_req),
    .sample_count   (items.sample_count),
    .min_value      (items.min_value),
    .avg_value      (items.avg_value),
    .max_value      (items.max_value),
    .dev_value      (items.dev_value),
    .kind           (results.kind),
    .repeat_out     (results.repeat_out),
    .count_out      (results.count_out),
    .min_out        (results.min_out),
    .avg_out        (results.avg_out),
    .max_out        (results.max_out),
    .dev_out        (results.dev_out),
    .last           (results.last)
  );

  // A passthrough record is always the final result of its item.
  assert property (@(posedge clk) disable iff (rst)
                   (results.valid && results.kind == KIND_PASS) |-> results.last)
    else $error("passthrough record without last");

  // No new item is taken while a result is pending.
  assert property (@(posedge clk) disable iff (rst) items.ready |-> !results.valid)
    else $error("item accepted while result pending");

  // A summary that is not last must be followed by a passthrough.
  assert property (@(posedge clk) disable iff (rst)
                   (results.valid && results.ready && !results.last) |=> !items.ready)
    else $error("missing passthrough after summary");

endmodule

FILE: tb/sv/bsd_tb_if.sv
`timescale 1ns / 1ps

// Bundle that carries the checker's failure count and open record count to the top.
interface bsd_mon_if;
  int fail_count;
  int pending;
endinterface

FILE: tb/sv/bsd_stats_checker.sv
`timescale 1ns / 1ps

module bsd_stats_checker (
  input  logic   clk,
  input  logic   rst,
  bsd_cfg_if     cfg,
  bsd_in_if      items,
  bsd_out_if     results,
  bsd_mon_if     mon
);
  import bsd_pkg::*;

  typedef struct packed {
    logic                         kind;
    logic [REP_W-1:0]             repeat_out;
    logic [OCNT_W-1:0]            count_out;
    logic signed [VALUE_BITS-1:0] min_out;
    logic signed [VALUE_BITS-1:0] avg_out;
    logic signed [VALUE_BITS-1:0] max_out;
    logic [DEV_W-1:0]             dev_out;
    logic                         last;
  } stat_rec_t;

  stat_rec_t record_queue[$];

  // Shadow copy of the block's register and pool.
  logic [REP_W-1:0] blk_size;
  logic [REP_W-1:0] fill_pos;
  logic [31:0]      pool_count;
  longint           pool_min, pool_max, pool_sum;
  logic [63:0]      pool_sq;

  localparam longint VMAXL = (64'sd1 <<< (VALUE_BITS - 1)) - 1;
  localparam longint VMINL = -VMAXL - 1;
  localparam logic [63:0] ALL_ONES = '1;

  assign mon.pending = record_queue.size();

  function automatic logic [63:0] magnitude(longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic [63:0] isqrt_round(logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return (x > r) ? r + 1 : r;
  endfunction

  task automatic empty_pool();
    pool_count = 0;
    pool_min = VMAXL;
    pool_max = VMINL;
    pool_sum = 0;
    pool_sq = 0;
  endtask

  task automatic pool_records(logic [63:0] k, logic [63:0] cnt, longint av, logic [63:0] dv);
    logic [63:0] a, sq, c, p;
    a = magnitude(av);
    sq = a * a + dv * dv;
    c = 64'(pool_count) + k * cnt;
    pool_count = (c > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : c[31:0];
    pool_sum += longint'(k) * av;
    if (k != 0 && sq > ALL_ONES / k) p = ALL_ONES;
    else p = sq * k;
    pool_sq = (pool_sq > ALL_ONES - p) ? ALL_ONES : pool_sq + p;
  endtask

  function automatic stat_rec_t close_block(logic [63:0] r);
    stat_rec_t s;
    logic [63:0] a, q, msq, rem, m2, var_v, dev;
    longint mean;
    a = magnitude(pool_sum);
    q = (a + r / 2) / r;
    if (pool_sum < 0) mean = (q > 64'(VMAXL) + 1) ? VMINL : -longint'(q);
    else mean = (q > 64'(VMAXL)) ? VMAXL : longint'(q);
    msq = pool_sq / r;
    rem = pool_sq % r;
    if (rem >= r - rem) msq++;
    m2 = magnitude(mean);
    m2 = m2 * m2;
    var_v = (msq > m2) ? msq - m2 : 0;
    dev = isqrt_round(var_v);
    if (dev > 64'((1 << DEV_W) - 1)) dev = 64'((1 << DEV_W) - 1);
    s.kind = KIND_SUMMARY;
    s.repeat_out = 1;
    s.count_out = pool_count;
    s.min_out = pool_min[VALUE_BITS-1:0];
    s.avg_out = mean[VALUE_BITS-1:0];
    s.max_out = pool_max[VALUE_BITS-1:0];
    s.dev_out = dev[DEV_W-1:0];
    s.last = 1'b0;
    return s;
  endfunction

  // Predicts the records caused by one input transaction.
  task automatic predict_records();
    logic [63:0] k, cnt, dv, r, take;
    longint mn, av, mx;
    stat_rec_t s;
    int produced;
    k = 64'(items.repeat_req);
    cnt = 64'(items.sample_count);
    mn = longint'(items.min_value);
    av = longint'(items.avg_value);
    mx = longint'(items.max_value);
    dv = 64'(items.dev_value);
    r = (blk_size == 0) ? 1 : 64'(blk_size);
    produced = 0;
    if (mn < pool_min) pool_min = mn;
    if (mx > pool_max) pool_max = mx;
    if (64'(fill_pos) + k >= r) begin
      take = (r > 64'(fill_pos)) ? r - 64'(fill_pos) : 0;
      pool_records(take, cnt, av, dv);
      record_queue.push_back(close_block(r));
      produced = 1;
      empty_pool();
      fill_pos = 0;
      k = k - take;
      if (k >= r) begin
        s.kind = KIND_PASS;
        s.repeat_out = REP_W'(k / r);
        s.count_out = 32'(cnt);
        s.min_out = items.min_value;
        s.avg_out = items.avg_value;
        s.max_out = items.max_value;
        s.dev_out = items.dev_value;
        s.last = 1'b0;
        record_queue.push_back(s);
        produced++;
        k = k % r;
      end
    end
    if (k > 0) begin
      pool_records(k, cnt, av, dv);
      fill_pos = fill_pos + REP_W'(k);
      if (mn < pool_min) pool_min = mn;
      if (mx > pool_max) pool_max = mx;
    end
    if (produced > 0) record_queue[$].last = 1'b1;
  endtask

  // Compares one output transaction with the oldest expected record.
  task automatic compare_record();
    stat_rec_t got, want;
    got = '{results.kind, results.repeat_out, results.count_out, results.min_out,
            results.avg_out, results.max_out, results.dev_out, results.last};
    if (record_queue.size() == 0) begin
      mon.fail_count++;
      if (mon.fail_count <= 10) $display("unexpected record %p", got);
    end else begin
      want = record_queue.pop_front();
      if (got !== want) begin
        mon.fail_count++;
        if (mon.fail_count <= 10) $display("record mismatch: expected %p, got %p", want, got);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      blk_size = BLOCK_SIZE_RESET;
      fill_pos = 0;
      mon.fail_count = 0;
      empty_pool();
      record_queue.delete();
    end else begin
      if (cfg.valid && cfg.ready) blk_size = cfg.block_size;
      if (items.valid && items.ready) predict_records();
      if (results.valid && results.ready) compare_record();
    end
  end

endmodule

FILE: tb/sv/tb_block_statistics_decimator_core.sv
`timescale 1ns / 1ps

module tb_block_statistics_decimator_core;
  import bsd_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   idle_cycles = 0;
  int   rx_count = 0;
  bit   hold_off = 1'b0;

  bsd_cfg_if cfg();
  bsd_in_if  items();
  bsd_out_if results();
  bsd_mon_if mon();

  block_statistics_decimator_core dut (
    .clk(clk), .rst(rst), .cfg(cfg), .items(items), .results(results)
  );

  bsd_stats_checker checker_i (
    .clk(clk), .rst(rst), .cfg(cfg), .items(items), .results(results), .mon(mon)
  );

  always #10 clk = ~clk;

  // Receiver: random stalls per record, with one long hold-off.
  always @(posedge clk) begin
    int wait_n;
    if (rst) begin
      results.ready <= 1'b0;
    end else begin
      if (rx_count == 150) begin
        results.ready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      wait_n = hold_off ? 0 : $urandom_range(0, 10);
      if ($urandom_range(0, 3) == 0) wait_n = 0;
      if (wait_n > 0) begin
        results.ready <= 1'b0;
        repeat (wait_n) @(posedge clk);
      end
      results.ready <= 1'b1;
      @(posedge clk);
      while (!results.valid) @(posedge clk);
      rx_count++;
    end
  end

  // Watchdog on cycles with no transaction.
  always @(posedge clk) begin
    if ((items.valid && items.ready) || (results.valid && results.ready) ||
        (cfg.valid && cfg.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic write_block_size(logic [REP_W-1:0] v);
    items.valid <= 1'b0;
    while (mon.pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.block_size <= v;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
  endtask

  task automatic send_record(logic [REP_W-1:0] rep, logic [CNT_W-1:0] cnt,
                             logic [VALUE_BITS-1:0] mn, logic [VALUE_BITS-1:0] av,
                             logic [VALUE_BITS-1:0] mx, logic [DEV_W-1:0] dv,
                             bit gaps);
    int n;
    n = gaps ? $urandom_range(0, 10) : 0;
    if (n > 0) begin
      items.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    items.valid <= 1'b1;
    items.repeat_req <= rep;
    items.sample_count <= cnt;
    items.min_value <= mn;
    items.avg_value <= av;
    items.max_value <= mx;
    items.dev_value <= dv;
    @(posedge clk);
    while (!items.ready) @(posedge clk);
  endtask

  // Random record with mostly ordered min <= avg <= max and some raw noise.
  task automatic send_random(logic [REP_W-1:0] bsz, bit gaps);
    logic [REP_W-1:0] rep;
    logic signed [VALUE_BITS-1:0] a, b, c, t;
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) rep = 0;
    else if (sel == 1) rep = REP_W'($urandom_range(0, 4096));
    else if (sel == 2) rep = REP_W'($urandom_range(1, 3) * (bsz == 0 ? 1 : bsz));
    else rep = REP_W'($urandom_range(1, (bsz > 3) ? bsz / 2 : 2));
    a = VALUE_BITS'($urandom);
    b = VALUE_BITS'($urandom);
    c = VALUE_BITS'($urandom);
    if (sel != 3) begin
      if (a > b) begin t = a; a = b; b = t; end
      if (b > c) begin t = b; b = c; c = t; end
      if (a > b) begin t = a; a = b; b = t; end
    end
    send_record(rep, CNT_W'($urandom), a, b, c, DEV_W'($urandom), gaps);
  endtask

  initial begin
    logic [REP_W-1:0] sizes[8];
    cfg.valid = 1'b0;
    cfg.block_size = '0;
    items.valid = 1'b0;
    items.repeat_req = '0;
    items.sample_count = '0;
    items.min_value = '0;
    items.avg_value = '0;
    items.max_value = '0;
    items.dev_value = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed records at the reset block size of ten.
    send_record(0, 16'hFFFF, VMIN, 0, VMAX, 0, 0);
    send_record(3, 16'hFFFF, VMAX, VMAX, VMAX, 23'h7FFFFF, 0);
    send_record(7, 16'hFFFF, VMIN, VMIN, VMIN, 23'h7FFFFF, 1);
    send_record(4095, 0, 24'h000001, 24'hFFFFFF, 24'h000002, 0, 0);
    send_record(4096, 16'hFFFF, VMIN, VMIN, VMAX, 23'h7FFFFF, 0);
    send_record(25, 1, 24'hFFF000, 24'h001000, 24'h002000, 23'h001000, 1);
    send_record(5, 5, VMIN, 24'hFFFFFF, 24'h000000, 0, 0);
    send_record(5, 5, 0, 24'h000001, 24'h000001, 0, 0);

    // Zero block size acts as one; then lower the size mid-block.
    write_block_size(0);
    send_record(1, 2, 3, 4, 5, 6, 0);
    send_record(3, 2, VMIN, VMAX, VMAX, 23'h7FFFFF, 0);
    write_block_size(4096);
    send_record(4000, 16'hFFFF, VMIN, VMAX, VMAX, 23'h7FFFFF, 0);
    write_block_size(3);
    send_record(1, 1, 0, 0, 0, 1, 0);
    send_record(2, 1, VMIN, VMIN, VMIN, 0, 0);
    write_block_size(1);
    send_record(8191, 16'hFFFF, VMIN, 24'h800001, VMAX, 23'h7FFFFF, 0);

    // Random phases across several block sizes.
    sizes = '{1, 2, 10, 7, 4096, 3, 5, 16};
    foreach (sizes[i]) begin
      write_block_size(sizes[i]);
      for (int n = 0; n < ((sizes[i] == 4096) ? 40 : 258); n++) begin
        hold_off = ($urandom_range(0, 7) == 0);
        send_random(sizes[i], !hold_off);
      end
    end
    items.valid <= 1'b0;

    while (mon.pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (mon.fail_count == 0 && mon.pending == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
